FILE: hdl/circular_fifo_queue_assert.svh
// ---------------------------------------------------------------------------
// circular fifo queue assertion macros
// shared concurrent assertion forms, clocked on aclk, off during reset
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_FIFO_QUEUE_ASSERT_SVH
`define CIRCULAR_FIFO_QUEUE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define CFQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// condition in one cycle implies a property in the next
`define CFQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) pre |=> post) \
        else $error(msg);

`endif

FILE: hdl/cfq_pkg.sv
// ---------------------------------------------------------------------------
// cfq_pkg
// shared sizes, codes, pointer helper and controller/datapath bundles
// ---------------------------------------------------------------------------
package cfq_pkg;

    localparam int DEPTH      = 8;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = ((CMD_W + DATA_W + 7) / 8) * 8;
    localparam int M_PAYLD_W  = 2 * DATA_W + 1;
    localparam int M_TDATA_W  = ((M_PAYLD_W + 7) / 8) * 8;

    typedef logic [ADDR_W-1:0]        ptr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [DATA_W-1:0] word_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_SHOW = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic take;     // request accepted this cycle
        logic exec;     // apply command to pointers and count
        logic walk_rd;  // read entry at walk pointer, advance it
        logic load;     // load output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic known_cmd;  // latched command is one of the three kinds
        logic out_free;   // output register can take a result this cycle
        logic more;       // display run has entries left after this one
    } dp_stat_t;

    function automatic ptr_t ptr_inc(ptr_t p);
        return (p == ptr_t'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

FILE: hdl/cfq_ram.sv
// ---------------------------------------------------------------------------
// cfq_ram
// generic ram, one write port and two registered read ports
// ---------------------------------------------------------------------------
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_a_en,
    input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
    output logic [WIDTH-1:0]         rd_a_data,
    input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
    output logic [WIDTH-1:0]         rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en) begin
            rd_a_data <= mem[rd_a_addr];
        end
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

FILE: hdl/cfq_dp.sv
// ---------------------------------------------------------------------------
// cfq_dp
// queue datapath: pointers, count, storage ram and output register
// ---------------------------------------------------------------------------
module cfq_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [cfq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  cfq_pkg::dp_cmd_t               ctl,
    output cfq_pkg::dp_stat_t              stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cfq_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [cfq_pkg::STATUS_W-1:0]   m_tuser,
    output logic                           m_tlast
);

    import cfq_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    logic [CMD_W-1:0] cmd_reg, cmd_next;
    word_t            val_reg, val_next;
    ptr_t             head_reg, head_next;
    ptr_t             tail_reg, tail_next;
    cnt_t             occ_reg, occ_next;
    ptr_t             walk_reg, walk_next;
    ptr_t             idx_reg, idx_next;
    status_t          status_reg, status_next;

    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    word_t            out_data_reg, out_data_next;
    word_t            out_front_reg, out_front_next;
    logic             out_empty_reg, out_empty_next;
    logic             out_last_reg, out_last_next;

    logic             wr_en;
    logic [DATA_W-1:0] rd_a_data, rd_b_data;
    logic             q_full, q_empty, at_end;

    logic [SUM_W-1:0] tail_sum;
    ptr_t             tail_expect;

    assign q_full  = (occ_reg == cnt_t'(DEPTH));
    assign q_empty = (occ_reg == '0);
    assign at_end  = ((cnt_t'(idx_reg) + cnt_t'(1)) == occ_reg);
    assign wr_en   = ctl.exec && (cmd_reg == CMD_ENQ) && !q_full;

    cfq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (tail_reg),
        .wr_data   (val_reg),
        .rd_a_en   (ctl.walk_rd),
        .rd_a_addr (walk_reg),
        .rd_a_data (rd_a_data),
        .rd_b_addr (head_reg),
        .rd_b_data (rd_b_data)
    );

    always_comb begin
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        walk_next       = walk_reg;
        idx_next        = idx_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_front_next  = out_front_reg;
        out_empty_next  = out_empty_reg;
        out_last_next   = out_last_reg;

        if (ctl.take) begin
            cmd_next = s_tdata[CMD_W-1:0];
            val_next = word_t'(s_tdata[CMD_W+DATA_W-1:CMD_W]);
        end

        if (ctl.exec) begin
            walk_next = head_reg;
            idx_next  = '0;
            case (cmd_reg)
                CMD_ENQ: begin
                    if (q_full) begin
                        status_next = ST_FULL;
                    end else begin
                        status_next = ST_OK;
                        tail_next   = ptr_inc(tail_reg);
                        occ_next    = occ_reg + 1'b1;
                    end
                end
                CMD_DEQ: begin
                    if (q_empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        status_next = ST_OK;
                        head_next   = ptr_inc(head_reg);
                        occ_next    = occ_reg - 1'b1;
                    end
                end
                CMD_SHOW: begin
                    status_next = q_empty ? ST_EMPTY : ST_OK;
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end

        if (ctl.walk_rd) begin
            walk_next = ptr_inc(walk_reg);
        end

        if (ctl.load) begin
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_data_next   = ((status_reg == ST_OK) && (cmd_reg != CMD_ENQ))
                              ? word_t'(rd_a_data) : '0;
            out_last_next   = (cmd_reg != CMD_SHOW) || (status_reg != ST_OK) || at_end;
            out_front_next  = q_empty ? '0 : word_t'(rd_b_data);
            out_empty_next  = q_empty;
            idx_next        = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        walk_reg       <= walk_next;
        idx_reg        <= idx_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_front_reg  <= out_front_next;
        out_empty_reg  <= out_empty_next;
        out_last_reg   <= out_last_next;
    end

    assign stat.known_cmd = cmd_reg inside {CMD_ENQ, CMD_DEQ, CMD_SHOW};
    assign stat.out_free  = !out_valid_reg || m_tready;
    assign stat.more      = (cmd_reg == CMD_SHOW) && (status_reg == ST_OK) && !at_end;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - M_PAYLD_W){1'b0}},
                       out_empty_reg, out_front_reg, out_data_reg};

    // tail always sits occupancy slots past head, modulo depth
    assign tail_sum    = SUM_W'(head_reg) + SUM_W'(occ_reg);
    assign tail_expect = (tail_sum >= SUM_W'(DEPTH)) ? ptr_t'(tail_sum - SUM_W'(DEPTH))
                                                     : ptr_t'(tail_sum);

    `include "circular_fifo_queue_assert.svh"

    `CFQ_ASSERT(a_occ_bound, occ_reg <= cnt_t'(DEPTH), "occupancy above depth")
    `CFQ_ASSERT(a_tail_track, tail_reg == tail_expect, "tail out of step with head and count")
    `CFQ_ASSERT_NEXT(a_wr_count, wr_en, occ_reg == cnt_t'($past(occ_reg) + 1'b1), "write without count step")
    `CFQ_ASSERT(a_empty_front, (out_valid_reg && out_empty_reg) |-> (out_front_reg == '0), "front nonzero on empty")

endmodule

FILE: hdl/cfq_ctrl.sv
// ---------------------------------------------------------------------------
// cfq_ctrl
// command sequencer: accept, execute, ram read, result load
// ---------------------------------------------------------------------------
module cfq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cfq_pkg::dp_stat_t  stat,
    output cfq_pkg::dp_cmd_t   ctl
);

    import cfq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_LOAD
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        ctl         = '0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                ctl.take = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                ctl.exec   = 1'b1;
                state_next = stat.known_cmd ? S_FETCH : S_IDLE;
            end
            S_FETCH: begin
                ctl.walk_rd = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD: begin
                // wait here while the output register is still occupied
                if (stat.out_free) begin
                    ctl.load   = 1'b1;
                    state_next = stat.more ? S_FETCH : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/circular_fifo_queue.sv
// ---------------------------------------------------------------------------
// circular_fifo_queue
// circular queue of signed 32-bit words with enqueue, dequeue and display
// ---------------------------------------------------------------------------
//
//  channel  dir  ports                       contents
//  s_       in   tvalid tready tdata         request: command and value
//  m_       out  tvalid tready tdata tuser   result: data, front, empty flag,
//                tlast                       status, end of run
//
//  enqueue and dequeue: accept, execute, ram read, then load into the output register;
//  intake reopens after the load
//  display of n entries: one ram read and one load per entry
//  the ram read step comes from the registered ram read and the single walk pointer
//  a stalled result holds the output register; the sequencer waits in load
//  reset clears head, tail, count and output valid; storage is not cleared
//
module circular_fifo_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cfq_pkg::S_TDATA_W-1:0] s_tdata,   // [1:0] cmd, [33:2] in_value
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cfq_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] data, [63:32] front_value,
                                                     // [64] is_empty
    output logic [cfq_pkg::STATUS_W-1:0]  m_tuser,   // [1:0] status
    output logic                          m_tlast
);

    import cfq_pkg::*;

    // command and status bundles between sequencer and datapath
    dp_cmd_t  ctl;
    dp_stat_t stat;

    // sequencer: one request at a time, walks entries for display
    cfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // datapath: pointers, count, storage ram, output register
    cfq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .ctl      (ctl),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: bench/circular_fifo_queue_test.sv
// ---------------------------------------------------------------------------
// circular_fifo_queue_test
// self-checking bench: a queue mirror predicts every result of each accepted
// request; directed corners first, then fill and drain phases of random
// requests with random idling on both channels
// ---------------------------------------------------------------------------
import cfq_pkg::*;

// one expected result, fields as the block reports them
typedef struct {
    status_t status;
    word_t   data;
    bit      last;
    word_t   front;
    bit      empty;
} queue_reply_t;

// mirror of the queue contents plus the results still owed by the block
class fifo_mirror;
    word_t        slots[DEPTH];
    ptr_t         head_ptr;
    ptr_t         tail_ptr;
    cnt_t         fill;
    queue_reply_t replies[$];
    int           failures;

    function new();
        head_ptr = '0;
        tail_ptr = '0;
        fill     = '0;
        failures = 0;
    endfunction

    function ptr_t step_slot(ptr_t p);
        return ptr_t'((int'(p) + 1) % DEPTH);
    endfunction

    // front and empty flag reflect the state after the request
    function void owe_reply(status_t st, word_t value, bit is_last);
        queue_reply_t r;
        r.status = st;
        r.data   = value;
        r.last   = is_last;
        r.empty  = (fill == '0);
        r.front  = r.empty ? word_t'(0) : slots[head_ptr];
        replies.push_back(r);
    endfunction

    // accepted request: update the mirror and queue the results it causes
    function void take_request(logic [CMD_W-1:0] op, word_t value);
        word_t popped;
        ptr_t  walk;
        case (op)
            CMD_ENQ: begin
                if (fill == cnt_t'(DEPTH)) begin
                    owe_reply(ST_FULL, '0, 1'b1);
                end else begin
                    slots[tail_ptr] = value;
                    tail_ptr = step_slot(tail_ptr);
                    fill++;
                    owe_reply(ST_OK, '0, 1'b1);
                end
            end
            CMD_DEQ: begin
                if (fill == '0) begin
                    owe_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    popped = slots[head_ptr];
                    head_ptr = step_slot(head_ptr);
                    fill--;
                    owe_reply(ST_OK, popped, 1'b1);
                end
            end
            CMD_SHOW: begin
                if (fill == '0) begin
                    owe_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    walk = head_ptr;
                    for (int i = 0; i < int'(fill); i++) begin
                        owe_reply(ST_OK, slots[walk], i == int'(fill) - 1);
                        walk = step_slot(walk);
                    end
                end
            end
            default: ;  // reserved command: nothing owed, state kept
        endcase
    endfunction

    // accepted result: compare with the oldest owed one
    function void match_reply(logic [STATUS_W-1:0] st, word_t value, logic is_last,
                              word_t front, logic empty);
        queue_reply_t r;
        if (replies.size() == 0) begin
            $error("unexpected result: status %0d data %0d", st, value);
            failures++;
            return;
        end
        r = replies.pop_front();
        if (st !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, st);
            failures++;
        end
        if (value !== r.data) begin
            $error("data: expected %0d, got %0d", r.data, value);
            failures++;
        end
        if (is_last !== r.last) begin
            $error("last: expected %0d, got %0d", r.last, is_last);
            failures++;
        end
        if (front !== r.front) begin
            $error("front_value: expected %0d, got %0d", r.front, front);
            failures++;
        end
        if (empty !== r.empty) begin
            $error("is_empty: expected %0d, got %0d", r.empty, empty);
            failures++;
        end
    endfunction
endclass

module circular_fifo_queue_test;

    // cmd value outside the three kinds; the block must drop it silently
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
    localparam int RANDOM_REQUESTS = 410;
    // no idling on either side for the last stretch of requests
    localparam int CALM_REQUESTS   = 60;
    // longest display run plus margin
    localparam int DRAIN_CYCLES    = 2 * DEPTH + 8;
    localparam int LIMIT_CYCLES    = 400_000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;

    bit         calm = 1'b0;
    fifo_mirror mirror = new();

    // boundary values for the directed fill
    word_t corner_words[8] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000,
                               -32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa,
                               32'sd1, 32'sh1234_5678};

    circular_fifo_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // present one request, hold it until accepted, then maybe idle a burst;
    // valid stays high when the next request follows at once
    task automatic send_request(input logic [CMD_W-1:0] op, input word_t value);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({value, op});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        mirror.take_request(op, value);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    // mostly full-range random words, now and then a boundary value
    function automatic word_t pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return word_t'($urandom());
        endcase
    endfunction

    // result side: ready in runs, stalled in bursts of random length
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    // result monitor: sampled at the edge, before the edge's updates land
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mirror.match_reply(m_tuser, m_tdata[DATA_W-1:0], m_tlast,
                               m_tdata[2*DATA_W-1:DATA_W], m_tdata[2*DATA_W]);
        end
    end

    initial begin
        int               sent;
        int               phase_left;
        int               roll;
        bit               filling;
        logic [CMD_W-1:0] op;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty queue reports, fill with boundary values,
        // full report, full display, reserved command, wrap of tail, drain
        send_request(CMD_SHOW, '0);
        send_request(CMD_DEQ, '0);
        for (int i = 0; i < DEPTH; i++) begin
            send_request(CMD_ENQ, corner_words[i % 8]);
        end
        send_request(CMD_ENQ, 32'sh0bad_cafe);
        send_request(CMD_SHOW, '0);
        send_request(CMD_RESERVED, -32'sd1);
        send_request(CMD_DEQ, '0);
        send_request(CMD_DEQ, '0);
        send_request(CMD_ENQ, -32'sd2);
        send_request(CMD_SHOW, '0);
        for (int i = 0; i < DEPTH - 1; i++) begin
            send_request(CMD_DEQ, '0);
        end

        // random: alternating fill-leaning and drain-leaning phases so the
        // queue swings between empty and full and the pointers wrap often
        sent       = 0;
        filling    = 1'b1;
        phase_left = $urandom_range(8, 40);
        while (sent < RANDOM_REQUESTS) begin
            calm = (sent >= RANDOM_REQUESTS - CALM_REQUESTS);
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(8, 40);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = CMD_RESERVED;
            else if (roll < 13)
                op = CMD_SHOW;
            else if (roll < (filling ? 75 : 35))
                op = CMD_ENQ;
            else
                op = CMD_DEQ;
            send_request(op, pick_value());
            // dropped commands don't count toward the run length
            if (op != CMD_RESERVED)
                sent++;
        end
        s_tvalid <= 1'b0;

        // wait for every owed result, then watch a while for strays
        while (mirror.replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mirror.failures == 0)
            $display("PASS circular_fifo_queue");
        else
            $display("FAIL circular_fifo_queue");
        $finish;
    end

    // watchdog, well above the slowest correct run
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("FAIL circular_fifo_queue");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/cfq_pkg.sv
hdl/cfq_ram.sv
hdl/cfq_dp.sv
hdl/cfq_ctrl.sv
hdl/circular_fifo_queue.sv
bench/circular_fifo_queue_test.sv
